// ===== design/bmsf_pkg.sv =====
// shared constants for the boruvka spanning forest block
`default_nettype none
package bmsf_pkg;
	localparam int VERTICES_DEF    = 64;
	localparam int EDGES_DEF       = 1024;
	localparam int WEIGHT_BITS_DEF = 32;

	localparam int VTX_W   = 6;   // stored endpoint width
	localparam int CFG_W   = 7;   // num_vertices width
	localparam int WIN_W   = 32;  // weight field width on the stream
	localparam int TOTAL_W = 38;
	localparam int UCNT_W  = 6;
	localparam int EIDX_W  = 10;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 56;

	localparam logic [CFG_W-1:0] NV_RESET = 7'd64;
endpackage
`default_nettype wire

// ===== design/boruvka_min_spanning_forest_top.sv =====
// top level: edge loading, boruvka round sequencer and result emission
// loading: one edge transaction per cycle while idle (s_tready high)
// run after the last_edge transaction, no input taken until the final result leaves:
//   an init write per vertex, then per round a root walk per vertex for flattening,
//   an offer check per stored edge and a merge step per vertex; rounds ~ log2(nv)
// emission: each edge is read and checked up to the last selected one, plus the handshake
// all work goes through one link ram, one pick ram, one edge ram and one compare unit
// arst_n clears control state and edge count; num_vertices resets to 64
`default_nettype none
module boruvka_min_spanning_forest_top #(
	parameter int VERTICES    = bmsf_pkg::VERTICES_DEF,
	parameter int EDGES       = bmsf_pkg::EDGES_DEF,
	parameter int WEIGHT_BITS = bmsf_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [bmsf_pkg::CFG_W-1:0] cfg_wdata,  // num_vertices
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [bmsf_pkg::IN_W-1:0]  s_tdata,    // edge_u, edge_v, edge_weight
	input  wire logic                       s_tlast,    // last_edge
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [bmsf_pkg::OUT_W-1:0]      m_tdata,    // edge_index, total_weight, union_count
	output logic [1:0]                      m_tuser,    // edge_found, overflow
	output logic                            m_tlast     // last
);
	import bmsf_pkg::*;

	localparam int WB    = WEIGHT_BITS;
	localparam int VW    = $clog2(VERTICES);
	localparam int IDX_W = (EDGES > 1) ? $clog2(EDGES) : 1;
	localparam int CNT_W = $clog2(EDGES + 1);
	localparam int EW    = 1 + 2 * VTX_W + WB;   // {mark, a, b, weight}
	localparam int PW    = 1 + IDX_W + WB;       // {none, index, weight}

	typedef enum logic [4:0] {
		IDLE, INIT, F_RD, F_WT, E_RD, E_CHK, E_LNK, E_OFA, E_OFB,
		U_RD, U_P, U_E, U_A, U_DO, R_END, X_START, X_RD, X_CHK, X_OUT
	} state_t;

	state_t state_q;

	// run control
	logic [CFG_W-1:0]  num_vertices_q, nv_q, i_q, rounds_q;
	logic [CNT_W-1:0]  cnt_q, e_q;
	logic              ovf_q;
	logic [VW-1:0]     p_q, ra_q, rb_q;
	logic [IDX_W-1:0]  pidx_q;
	logic [EW-1:0]     word_q;
	logic [PW-1:0]     pickb_q;
	logic [UCNT_W-1:0] unions_q, old_q, emitted_q;
	logic [TOTAL_W-1:0] total_q;

	// output register
	logic [EIDX_W-1:0]  out_idx_q;
	logic               out_found_q, out_ovf_q, out_last_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic [UCNT_W-1:0]  out_unions_q;

	// memories
	logic             edge_we;
	logic [IDX_W-1:0] edge_waddr, edge_raddr;
	logic [EW-1:0]    edge_wdata, edge_rdata;
	logic             link_we;
	logic [VW-1:0]    link_waddr, link_wdata, link_ra, link_rb, link_rdata_a, link_rdata_b;
	logic             pick_we;
	logic [VW-1:0]    pick_waddr, pick_ra, pick_rb;
	logic [PW-1:0]    pick_wdata, pick_rdata_a, pick_rdata_b;

	logic [PW-1:0]    cur_pick;
	logic             take;

	logic [CFG_W-1:0] i_nxt;
	logic [CNT_W-1:0] e_nxt;
	logic [VTX_W-1:0] rd_a, rd_b, wq_a, wq_b, join_v;
	logic [EIDX_W+CNT_W-1:0] e_ext;
	logic             load_ok, round_stop;

	assign i_nxt   = i_q + CFG_W'(1);
	assign e_nxt   = e_q + CNT_W'(1);
	assign rd_a    = edge_rdata[WB+2*VTX_W-1:WB+VTX_W];
	assign rd_b    = edge_rdata[WB+VTX_W-1:WB];
	assign wq_a    = word_q[WB+2*VTX_W-1:WB+VTX_W];
	assign wq_b    = word_q[WB+VTX_W-1:WB];
	assign join_v  = (i_q == {1'b0, wq_a}) ? wq_b : wq_a;
	assign e_ext   = {{EIDX_W{1'b0}}, e_q};
	assign load_ok = cnt_q < CNT_W'(EDGES);
	assign round_stop = (rounds_q > nv_q) || (unions_q == old_q) ||
		({1'b0, unions_q} >= nv_q - CFG_W'(1));
	assign cur_pick = (state_q == E_OFB) ? pickb_q : pick_rdata_a;

	bmsf_ram #(.WIDTH(EW), .DEPTH(EDGES), .AW(IDX_W)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.raddr_a(edge_raddr), .rdata_a(edge_rdata), .raddr_b(edge_raddr), .rdata_b()
	);

	bmsf_ram #(.WIDTH(VW), .DEPTH(VERTICES), .AW(VW)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.raddr_a(link_ra), .rdata_a(link_rdata_a), .raddr_b(link_rb), .rdata_b(link_rdata_b)
	);

	bmsf_ram #(.WIDTH(PW), .DEPTH(VERTICES), .AW(VW)) u_pick_ram (
		.clk(clk), .we(pick_we), .waddr(pick_waddr), .wdata(pick_wdata),
		.raddr_a(pick_ra), .rdata_a(pick_rdata_a), .raddr_b(pick_rb), .rdata_b(pick_rdata_b)
	);

	bmsf_cheaper #(.IDX_W(IDX_W), .WB(WB)) u_cheaper (
		.new_w(word_q[WB-1:0]), .new_idx(e_q[IDX_W-1:0]),
		.cur_none(cur_pick[PW-1]), .cur_w(cur_pick[WB-1:0]),
		.cur_idx(cur_pick[WB+IDX_W-1:WB]), .take(take)
	);

	// memory port steering
	always_comb begin
		edge_we    = 1'b0;
		edge_waddr = cnt_q[IDX_W-1:0];
		edge_wdata = {1'b0, s_tdata[VTX_W-1:0], s_tdata[2*VTX_W-1:VTX_W],
			s_tdata[2*VTX_W+WB-1:2*VTX_W]};
		edge_raddr = e_q[IDX_W-1:0];
		link_we    = 1'b0;
		link_waddr = i_q[VW-1:0];
		link_wdata = i_q[VW-1:0];
		link_ra    = p_q;
		link_rb    = p_q;
		pick_we    = 1'b0;
		pick_waddr = i_q[VW-1:0];
		pick_wdata = {1'b1, {(PW-1){1'b0}}};
		pick_ra    = i_q[VW-1:0];
		pick_rb    = i_q[VW-1:0];
		unique case (state_q)
			IDLE: begin
				edge_we = s_tvalid && load_ok;
			end
			INIT: begin
				link_we = 1'b1;
			end
			F_WT: begin
				if (link_rdata_a == p_q) begin
					link_we    = 1'b1;
					link_wdata = p_q;
					pick_we    = 1'b1;
				end
			end
			E_CHK: begin
				link_ra = rd_a[VW-1:0];
				link_rb = rd_b[VW-1:0];
			end
			E_LNK: begin
				edge_we    = 1'b1;
				edge_waddr = e_q[IDX_W-1:0];
				edge_wdata = {word_q[EW-1], VTX_W'(link_rdata_a), VTX_W'(link_rdata_b),
					word_q[WB-1:0]};
				pick_ra    = link_rdata_a;
				pick_rb    = link_rdata_b;
			end
			E_OFA: begin
				pick_we    = take;
				pick_waddr = ra_q;
				pick_wdata = {1'b0, e_q[IDX_W-1:0], word_q[WB-1:0]};
			end
			E_OFB: begin
				pick_we    = take;
				pick_waddr = rb_q;
				pick_wdata = {1'b0, e_q[IDX_W-1:0], word_q[WB-1:0]};
			end
			U_P: begin
				edge_raddr = pick_rdata_a[WB+IDX_W-1:WB];
			end
			U_E: begin
				pick_rb = rd_a[VW-1:0];
			end
			U_DO: begin
				edge_we    = 1'b1;
				edge_waddr = pidx_q;
				edge_wdata = {1'b1, word_q[EW-2:0]};
				link_we    = 1'b1;
				link_wdata = join_v[VW-1:0];
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= IDLE;
			num_vertices_q <= NV_RESET;
			cnt_q          <= '0;
			ovf_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_vertices_q <= cfg_wdata;
			end
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						if (load_ok) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							nv_q     <= (num_vertices_q > CFG_W'(VERTICES)) ?
								CFG_W'(VERTICES) : num_vertices_q;
							i_q      <= '0;
							unions_q <= '0;
							old_q    <= '0;
							total_q  <= '0;
							rounds_q <= CFG_W'(1);
							// zero vertices: straight to the empty result
							state_q  <= (num_vertices_q == '0) ? X_START : INIT;
						end
					end
				end
				INIT: begin
					// every vertex starts as its own component
					if (i_nxt < nv_q) begin
						i_q <= i_nxt;
					end else begin
						i_q     <= '0;
						p_q     <= '0;
						state_q <= F_RD;
					end
				end
				F_RD: state_q <= F_WT;
				F_WT: begin
					if (link_rdata_a == p_q) begin
						// root found, link written, pick cleared
						if (i_nxt < nv_q) begin
							i_q     <= i_nxt;
							p_q     <= i_nxt[VW-1:0];
							state_q <= F_RD;
						end else begin
							i_q     <= '0;
							e_q     <= '0;
							state_q <= (cnt_q != '0) ? E_RD : U_RD;
						end
					end else begin
						p_q     <= link_rdata_a;
						state_q <= F_RD;
					end
				end
				E_RD: state_q <= E_CHK;
				E_CHK: begin
					word_q <= edge_rdata;
					if (({1'b0, rd_a} >= nv_q) || ({1'b0, rd_b} >= nv_q)) begin
						// out-of-range edge is ignored
						e_q     <= e_nxt;
						state_q <= (e_nxt < cnt_q) ? E_RD : U_RD;
					end else begin
						state_q <= E_LNK;
					end
				end
				E_LNK: begin
					ra_q <= link_rdata_a;
					rb_q <= link_rdata_b;
					if (link_rdata_a == link_rdata_b) begin
						e_q     <= e_nxt;
						state_q <= (e_nxt < cnt_q) ? E_RD : U_RD;
					end else begin
						state_q <= E_OFA;
					end
				end
				E_OFA: begin
					pickb_q <= pick_rdata_b;
					state_q <= E_OFB;
				end
				E_OFB: begin
					e_q     <= e_nxt;
					state_q <= (e_nxt < cnt_q) ? E_RD : U_RD;
				end
				U_RD: state_q <= U_P;
				U_P: begin
					if (pick_rdata_a[PW-1]) begin
						i_q     <= i_nxt;
						state_q <= (i_nxt < nv_q) ? U_RD : R_END;
					end else begin
						pidx_q  <= pick_rdata_a[WB+IDX_W-1:WB];
						state_q <= U_E;
					end
				end
				U_E: begin
					word_q  <= edge_rdata;
					state_q <= ({1'b0, rd_b} == i_q) ? U_A : U_DO;
				end
				U_A: begin
					// both components chose this edge: merge only from the first endpoint
					if (!pick_rdata_b[PW-1] && (pick_rdata_b[WB+IDX_W-1:WB] == pidx_q)) begin
						i_q     <= i_nxt;
						state_q <= (i_nxt < nv_q) ? U_RD : R_END;
					end else begin
						state_q <= U_DO;
					end
				end
				U_DO: begin
					unions_q <= unions_q + UCNT_W'(1);
					total_q  <= total_q + TOTAL_W'($signed(word_q[WB-1:0]));
					i_q      <= i_nxt;
					state_q  <= (i_nxt < nv_q) ? U_RD : R_END;
				end
				R_END: begin
					if (round_stop) begin
						state_q <= X_START;
					end else begin
						rounds_q <= rounds_q + CFG_W'(1);
						old_q    <= unions_q;
						i_q      <= '0;
						p_q      <= '0;
						state_q  <= F_RD;
					end
				end
				X_START: begin
					e_q       <= '0;
					emitted_q <= '0;
					if (unions_q == '0) begin
						out_idx_q    <= '0;
						out_found_q  <= 1'b0;
						out_total_q  <= total_q;
						out_unions_q <= unions_q;
						out_ovf_q    <= ovf_q;
						out_last_q   <= 1'b1;
						state_q      <= X_OUT;
					end else begin
						state_q <= X_RD;
					end
				end
				X_RD: state_q <= X_CHK;
				X_CHK: begin
					// marked edges count equals the union count
					if (edge_rdata[EW-1]) begin
						out_idx_q   <= e_ext[EIDX_W-1:0];
						out_found_q <= 1'b1;
						out_ovf_q   <= ovf_q;
						emitted_q   <= emitted_q + UCNT_W'(1);
						if (emitted_q + UCNT_W'(1) == unions_q) begin
							out_last_q   <= 1'b1;
							out_total_q  <= total_q;
							out_unions_q <= unions_q;
						end else begin
							out_last_q   <= 1'b0;
							out_total_q  <= '0;
							out_unions_q <= '0;
						end
						state_q <= X_OUT;
					end else begin
						e_q     <= e_nxt;
						state_q <= X_RD;
					end
				end
				X_OUT: begin
					if (m_tready) begin
						if (out_last_q) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= IDLE;
						end else begin
							e_q     <= e_nxt;
							state_q <= X_RD;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = (state_q == X_OUT);
	assign m_tdata  = {2'b00, out_unions_q, out_total_q, out_idx_q};
	assign m_tuser  = {out_ovf_q, out_found_q};
	assign m_tlast  = out_last_q;

	// a run never overlaps loading
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result is pending");

	// the empty result is always the final one
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tlast)
		else $error("empty result not marked last");

	// totals only ride on the final transaction
	a_totals_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[53:10] == '0))
		else $error("totals on a non-final result");
endmodule
`default_nettype wire

// ===== design/bmsf_ram.sv =====
// generic ram, one write port, two registered read ports
`default_nettype none
module bmsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	output logic      [WIDTH-1:0] rdata_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
`default_nettype wire

// ===== design/bmsf_cheaper.sv =====
// shared weight/index compare unit for the cheapest-edge offers
`default_nettype none
module bmsf_cheaper #(
	parameter int IDX_W = 10,
	parameter int WB    = 32
) (
	input  wire logic [WB-1:0]    new_w,
	input  wire logic [IDX_W-1:0] new_idx,
	input  wire logic             cur_none,
	input  wire logic [WB-1:0]    cur_w,
	input  wire logic [IDX_W-1:0] cur_idx,
	output logic                  take
);
	always_comb begin
		if (cur_none) begin
			take = 1'b1;
		end else if (new_w != cur_w) begin
			take = $signed(new_w) < $signed(cur_w);
		end else begin
			take = new_idx < cur_idx;
		end
	end
endmodule
`default_nettype wire

// ===== verif/boruvka_min_spanning_forest_top_test.sv =====
// testbench for the boruvka spanning forest block: directed and random edge runs
`timescale 1ns / 100ps
`default_nettype none
module boruvka_min_spanning_forest_top_test;
	import bmsf_pkg::*;

	localparam int NV_MAX    = 64;
	localparam int CAP       = 1024;
	localparam int RES_CAP   = 63;
	localparam int IDLE_LIMIT = 2000000;  // cycles without any transaction
	localparam int SETTLE    = 40;

	typedef struct packed {
		logic [EIDX_W-1:0]         index;
		logic                      found;
		logic signed [TOTAL_W-1:0] total;
		logic [UCNT_W-1:0]         unions;
		logic                      ovf;
		logic                      last;
	} forest_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	// mirror of the block's loaded edges and run state
	logic [VTX_W-1:0]    end_a[CAP];
	logic [VTX_W-1:0]    end_b[CAP];
	logic signed [31:0]  wt[CAP];
	bit                  picked[CAP];
	int                  link[NV_MAX];
	int                  cheap[NV_MAX];
	int                  loaded;
	bit                  dropped;
	int                  nv_reg;

	forest_result_t      pending[$];
	int                  errors;
	int                  idle_pct;
	int                  stall_pct;
	int                  quiet;

	boruvka_min_spanning_forest_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int find_root(int v);
		int p;
		int steps;
		p = link[v % NV_MAX] % NV_MAX;
		steps = 0;
		while (link[p] != p && steps < NV_MAX) begin
			p = link[p] % NV_MAX;
			steps++;
		end
		return p;
	endfunction

	function automatic bit beats(int a, int b);
		if (a == b) return 0;
		if (wt[a] != wt[b]) return wt[a] < wt[b];
		return a < b;
	endfunction

	function automatic void reset_forest();
		for (int i = 0; i < NV_MAX; i++) begin
			link[i] = i;
			cheap[i] = CAP;
		end
		for (int i = 0; i < CAP; i++) picked[i] = 0;
	endfunction

	// boruvka rounds over the loaded edges, then queue the selected edge list
	function automatic void solve_forest();
		int nv;
		int rounds;
		int unions;
		int old_unions;
		int a;
		int b;
		int j;
		int p;
		int k;
		logic signed [63:0] sum;
		forest_result_t r;
		nv = (nv_reg > NV_MAX) ? NV_MAX : nv_reg;
		reset_forest();
		unions = 0;
		rounds = 0;
		sum = 0;
		k = 0;
		if (nv > 0) begin
			forever begin
				old_unions = unions;
				rounds++;
				for (int i = 0; i < nv; i++) begin
					cheap[i] = CAP;
					link[i] = find_root(i);
				end
				for (int e = 0; e < loaded; e++) begin
					a = end_a[e];
					b = end_b[e];
					if (a >= nv || b >= nv) continue;
					a = link[a];
					b = link[b];
					end_a[e] = a;
					end_b[e] = b;
					if (a == b) continue;
					if (cheap[a] >= CAP || beats(e, cheap[a])) cheap[a] = e;
					if (cheap[b] >= CAP || beats(e, cheap[b])) cheap[b] = e;
				end
				for (int i = 0; i < nv; i++) begin
					p = cheap[i];
					if (p >= CAP) continue;
					a = end_a[p];
					b = end_b[p];
					j = (i == a) ? b : a;
					// both components chose this edge: merge once only
					if (b == i && cheap[a % NV_MAX] == p) continue;
					picked[p] = 1;
					link[i] = j % NV_MAX;
					unions++;
					sum += wt[p];
				end
				if (rounds > nv) break;
				if (unions == old_unions || unions >= nv - 1) break;
			end
		end
		for (int e = 0; e < loaded && k < RES_CAP; e++) begin
			if (!picked[e]) continue;
			r = '0;
			r.index = e;
			r.found = 1'b1;
			r.ovf = dropped;
			pending.push_back(r);
			k++;
		end
		if (k == 0) begin
			r = '0;
			r.ovf = dropped;
			pending.push_back(r);
		end
		r = pending.pop_back();
		r.total = sum[TOTAL_W-1:0];
		r.unions = unions[UCNT_W-1:0];
		r.last = 1'b1;
		pending.push_back(r);
		loaded = 0;
		dropped = 0;
		reset_forest();
	endfunction

	// one edge transaction; valid stays high into the next call unless a gap is taken
	task automatic send_edge(input logic [VTX_W-1:0] u, input logic [VTX_W-1:0] v,
			input logic [31:0] w, input logic fin);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, w, v, u};
		s_tlast <= fin;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		if (loaded < CAP) begin
			end_a[loaded] = u;
			end_b[loaded] = v;
			wt[loaded] = w;
			loaded++;
		end else begin
			dropped = 1;
		end
		if (fin) solve_forest();
	endtask

	// register write only once the block is idle and every result is back
	task automatic set_vertices(input int n);
		s_tvalid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= n[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		nv_reg = n & 7'h7f;
	endtask

	task automatic test_small_graph();
		set_vertices(4);
		send_edge(0, 1, 32'sd5, 0);
		send_edge(1, 2, 32'sd5, 0);        // tie with the first edge
		send_edge(2, 3, 32'h8000_0000, 0); // most negative weight
		send_edge(3, 0, 32'h7fff_ffff, 0); // most positive weight
		send_edge(0, 9, 32'sd1, 0);        // endpoint out of range
		send_edge(2, 2, 32'sd0, 0);        // self loop
		send_edge(1, 3, -32'sd7, 1);
	endtask

	task automatic test_empty_runs();
		set_vertices(0);
		send_edge(0, 1, 32'sd3, 1);
		set_vertices(1);
		send_edge(0, 0, 32'sd3, 1);
		set_vertices(2);
		send_edge(1, 5, 32'sd3, 1);
	endtask

	task automatic test_wide_graph();
		set_vertices(127);                  // above the vertex count, clamps
		send_edge(63, 0, 32'hffff_ffff, 0);
		send_edge(0, 63, 32'hffff_ffff, 0); // parallel edge, same weight
		send_edge(42, 21, 32'h5555_5555, 0);
		send_edge(21, 42, 32'haaaa_aaaa, 0);
		send_edge(63, 42, 32'sd0, 1);
	endtask

	task automatic test_store_full();
		set_vertices(8);
		for (int i = 0; i < CAP + 6; i++)
			send_edge($urandom_range(7), $urandom_range(7), $urandom, i == CAP + 5);
	endtask

	task automatic random_phase(input int items, input int gap, input int stall);
		int done;
		int len;
		int n;
		idle_pct = gap;
		stall_pct = stall;
		done = 0;
		while (done < items) begin
			case ($urandom_range(5))
				0: n = 64;
				1: n = $urandom_range(2, 4);
				2: n = $urandom_range(5, 16);
				3: n = $urandom_range(17, 64);
				4: n = $urandom_range(0, 1);
				default: n = $urandom_range(65, 127);
			endcase
			set_vertices(n);
			len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
			for (int i = 0; i < len; i++) begin
				logic [VTX_W-1:0] u;
				logic [VTX_W-1:0] v;
				logic [31:0] w;
				int hi;
				hi = (n > NV_MAX) ? NV_MAX - 1 : ((n > 0) ? n - 1 : 0);
				if ($urandom_range(9) == 0) begin
					u = $urandom;
					v = $urandom;
				end else begin
					u = $urandom_range(hi);
					v = $urandom_range(hi);
				end
				w = $urandom_range(1) ? $signed($urandom_range(8)) - 4 : $urandom;
				send_edge(u, v, w, i == len - 1);
			end
			done += len;
		end
	endtask

	// result checker against the oldest expected entry
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			forest_result_t want;
			forest_result_t got;
			got.index = m_tdata[EIDX_W-1:0];
			got.total = m_tdata[EIDX_W+TOTAL_W-1:EIDX_W];
			got.unions = m_tdata[EIDX_W+TOTAL_W+UCNT_W-1:EIDX_W+TOTAL_W];
			got.found = m_tuser[0];
			got.ovf = m_tuser[1];
			got.last = m_tlast;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, actual %p", $time, got);
				errors++;
			end else begin
				want = pending.pop_front();
				if (got !== want) begin
					$display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		errors = 0;
		quiet = 0;
		idle_pct = 0;
		stall_pct = 0;
		loaded = 0;
		dropped = 0;
		nv_reg = NV_RESET;
		reset_forest();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_graph();
		test_empty_runs();
		test_wide_graph();
		test_store_full();
		random_phase(95, 0, 0);
		random_phase(95, 50, 0);
		random_phase(95, 0, 50);
		random_phase(95, 13, 13);

		s_tvalid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== boruvka_min_spanning_forest_top.f =====
design/bmsf_pkg.sv
design/bmsf_ram.sv
design/bmsf_cheaper.sv
design/boruvka_min_spanning_forest_top.sv
verif/boruvka_min_spanning_forest_top_test.sv
